// ----- hdl/ggnh_pkg.sv -----
// Shared types, constants and codes for the geographic next-hop table.
package ggnh_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DIST_W = 34;

    localparam logic [2:0] FN_ADD    = 3'd0;
    localparam logic [2:0] FN_UPDATE = 3'd1;
    localparam logic [2:0] FN_DELETE = 3'd2;
    localparam logic [2:0] FN_LOOKUP = 3'd3;
    localparam logic [2:0] FN_PREDICT = 3'd4;
    localparam logic [2:0] FN_QUERY  = 3'd5;

    localparam logic [15:0] RANGE_RESET = 16'd250;

    typedef struct packed {
        logic [2:0]         func;
        logic [31:0]        node_addr;
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic [15:0]        pos_z;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
        logic [15:0]        stamp_or_now;
    } t_in_item;

    typedef struct packed {
        logic               success;
        logic [31:0]        next_hop;
        logic [15:0]        res_x;
        logic [15:0]        res_y;
        logic [15:0]        res_z;
        logic signed [15:0] res_vx;
        logic signed [15:0] res_vy;
        logic signed [15:0] res_vz;
        logic [15:0]        res_stamp;
        logic [4:0]         entry_count;
        logic               recovery_ok;
    } t_out_item;

    typedef struct packed {
        logic [31:0]       key;
        logic [2:0][15:0]  pos;
        logic [2:0][15:0]  vel;
        logic [15:0]       stamp;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic load;
        logic exec;
        logic start_scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic hit;
        logic is_query;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/ggnh_ram.sv -----
// Generic single-port-write RAM with registered read.
module ggnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/ggnh_ctrl.sv -----
// Controller state machine sequencing the table operations.
module ggnh_ctrl import ggnh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FIND = 5'b00010,
        ST_EXEC = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_RES  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                if (!i_sts.busy) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.is_query && i_sts.hit) begin
                    o_cmd.start_scan = 1'b1;
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_RES;
                end
            end
            ST_SCAN: begin
                if (!i_sts.busy) begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ----- hdl/ggnh_dpath.sv -----
// Datapath: record store, slot scan pipeline, table update and result register.
module ggnh_dpath import ggnh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  t_in_item  i_in_data,
    input  logic [15:0] i_range,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

    function automatic logic [15:0] absdiff(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    t_in_item r_in;
    logic [DEPTH-1:0] r_valid;
    logic [CNT_W-1:0] r_count;
    logic [31:0] r_rng2;

    logic r_iss_on, r_scan;
    logic [IDX_W-1:0] r_cnt;

    logic r_q_v, r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;
    logic [IDX_W-1:0] r_q_idx, r_s1_idx, r_s2_idx, r_s3_idx, r_s4_idx, r_s5_idx;
    t_rec q_rec, r_s1_rec, r_s2_rec;
    logic [2:0][15:0] r_s1_mv, r_s2_p;
    logic [2:0][15:0] r_s3_dm, r_s3_dd;
    logic [2:0][31:0] r_s4_dm, r_s4_dd;
    logic [31:0] r_s3_key, r_s4_key, r_s5_key;
    logic [DIST_W-1:0] r_s5_dm, r_s5_dd;

    logic r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    t_rec r_hit_rec;
    logic [2:0][15:0] r_hit_p;

    logic r_any;
    logic [DIST_W-1:0] r_best_d, r_dme;
    logic [31:0] r_best_a;
    logic r_ok;

    logic r_out_v;
    t_out_item r_out, n_out;

    logic free_any;
    logic [IDX_W-1:0] free_idx;
    logic we;
    logic [IDX_W-1:0] waddr;
    t_rec wrec;
    logic [15:0] dt;
    logic [2:0][15:0] me;
    logic nb, better;
    logic [31:0] nh;

    assign me[0] = r_in.pos_x;
    assign me[1] = r_in.pos_y;
    assign me[2] = r_in.pos_z;

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        wrec.key = r_in.node_addr;
        wrec.pos[0] = r_in.pos_x;
        wrec.pos[1] = r_in.pos_y;
        wrec.pos[2] = r_in.pos_z;
        wrec.vel[0] = $unsigned(r_in.vel_x);
        wrec.vel[1] = $unsigned(r_in.vel_y);
        wrec.vel[2] = $unsigned(r_in.vel_z);
        wrec.stamp = r_in.stamp_or_now;
        we = 1'b0;
        waddr = r_hit_idx;
        if (i_cmd.exec) begin
            if (r_in.func == FN_ADD && !r_hit && free_any) begin
                we = 1'b1;
                waddr = free_idx;
            end else if (r_in.func == FN_UPDATE && r_hit) begin
                we = 1'b1;
            end
        end
    end

    ggnh_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wrec),
        .i_raddr(r_cnt),
        .o_rdata(q_rec)
    );

    assign dt = r_in.stamp_or_now - q_rec.stamp;
    assign nb = r_valid[r_s5_idx] && (r_s5_dm <= {2'b00, r_rng2});
    assign better = !r_any || (r_s5_dd < r_best_d)
                    || (r_s5_dd == r_best_d && r_s5_key < r_best_a);

    always_ff @(posedge i_clk) begin
        r_rng2 <= i_range * i_range;
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        for (int a = 0; a < 3; a++) begin
            r_s1_mv[a] <= 16'(dt * q_rec.vel[a]);
            r_s2_p[a] <= r_s1_rec.pos[a] + r_s1_mv[a];
            r_s3_dm[a] <= absdiff(r_s2_p[a], me[a]);
            r_s3_dd[a] <= absdiff(r_s2_p[a], r_hit_p[a]);
            r_s4_dm[a] <= r_s3_dm[a] * r_s3_dm[a];
            r_s4_dd[a] <= r_s3_dd[a] * r_s3_dd[a];
        end
        r_s1_rec <= q_rec;
        r_s2_rec <= r_s1_rec;
        r_s3_key <= r_s2_rec.key;
        r_s4_key <= r_s3_key;
        r_s5_key <= r_s4_key;
        r_s5_dm <= DIST_W'(r_s4_dm[0]) + DIST_W'(r_s4_dm[1]) + DIST_W'(r_s4_dm[2]);
        r_s5_dd <= DIST_W'(r_s4_dd[0]) + DIST_W'(r_s4_dd[1]) + DIST_W'(r_s4_dd[2]);
        r_q_idx <= r_cnt;
        r_s1_idx <= r_q_idx;
        r_s2_idx <= r_s1_idx;
        r_s3_idx <= r_s2_idx;
        r_s4_idx <= r_s3_idx;
        r_s5_idx <= r_s4_idx;
        if (r_s2_v && !r_scan && r_valid[r_s2_idx] && r_s2_rec.key == r_in.node_addr) begin
            r_hit_idx <= r_s2_idx;
            r_hit_rec <= r_s2_rec;
            r_hit_p <= r_s2_p;
        end
        if (r_s5_v && r_scan) begin
            if (nb && better) begin
                r_best_d <= r_s5_dd;
                r_best_a <= r_s5_key;
            end
            if (r_s5_idx == r_hit_idx) begin
                r_dme <= r_s5_dm;
            end
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_iss_on <= 1'b0;
            r_scan <= 1'b0;
            r_cnt <= '0;
            r_q_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_hit <= 1'b0;
            r_any <= 1'b0;
            r_ok <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_q_v <= r_iss_on;
            r_s1_v <= r_q_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            if (i_cmd.load || i_cmd.start_scan) begin
                r_iss_on <= 1'b1;
                r_cnt <= '0;
                r_scan <= i_cmd.start_scan;
            end else if (r_iss_on) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_iss_on <= 1'b0;
                end
            end
            if (i_cmd.load) begin
                r_hit <= 1'b0;
            end else if (r_s2_v && !r_scan && r_valid[r_s2_idx]
                         && r_s2_rec.key == r_in.node_addr) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.start_scan) begin
                r_any <= 1'b0;
            end else if (r_s5_v && r_scan && nb) begin
                r_any <= 1'b1;
            end
            if (i_cmd.exec) begin
                r_ok <= 1'b0;
                case (r_in.func) inside
                    FN_ADD: begin
                        if (!r_hit && free_any) begin
                            r_valid[free_idx] <= 1'b1;
                            r_count <= r_count + 1'b1;
                            r_ok <= 1'b1;
                        end
                    end
                    FN_DELETE: begin
                        if (r_hit) begin
                            r_valid[r_hit_idx] <= 1'b0;
                            r_count <= r_count - 1'b1;
                            r_ok <= 1'b1;
                        end
                    end
                    FN_UPDATE, FN_LOOKUP, FN_PREDICT: r_ok <= r_hit;
                    default: r_ok <= 1'b0;
                endcase
            end
            if (i_cmd.finish) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_comb begin
        n_out = '0;
        n_out.entry_count = 5'(r_count);
        nh = (r_any && r_dme > r_best_d) ? r_best_a : 32'd0;
        case (r_in.func) inside
            FN_ADD, FN_UPDATE, FN_DELETE: n_out.success = r_ok;
            FN_LOOKUP: begin
                if (r_hit) begin
                    n_out.success = 1'b1;
                    n_out.res_x = r_hit_rec.pos[0];
                    n_out.res_y = r_hit_rec.pos[1];
                    n_out.res_z = r_hit_rec.pos[2];
                    n_out.res_vx = r_hit_rec.vel[0];
                    n_out.res_vy = r_hit_rec.vel[1];
                    n_out.res_vz = r_hit_rec.vel[2];
                    n_out.res_stamp = r_hit_rec.stamp;
                end
            end
            FN_PREDICT: begin
                if (r_hit) begin
                    n_out.success = 1'b1;
                    n_out.res_x = r_hit_p[0];
                    n_out.res_y = r_hit_p[1];
                    n_out.res_z = r_hit_p[2];
                end
            end
            FN_QUERY: begin
                if (r_hit) begin
                    n_out.recovery_ok = r_any;
                    n_out.next_hop = nh;
                    n_out.success = (nh != 32'd0);
                end
            end
            default: n_out.success = 1'b0;
        endcase
    end

    assign o_sts.busy = r_iss_on | r_q_v | r_s1_v | r_s2_v | r_s3_v | r_s4_v | r_s5_v;
    assign o_sts.hit = r_hit;
    assign o_sts.is_query = (r_in.func == FN_QUERY);
    assign o_sts.out_free = !r_out_v || !i_out_stall;
    assign o_out_valid = r_out_v;
    assign o_out_data = r_out;

endmodule

// ----- hdl/greedy_geo_next_hop_table.sv -----
// Top level of the greedy geographic next-hop table with its register port.
//
// Input beats carry one table operation each (add, update, delete, lookup,
// predict, next-hop query) on i_in_data; every beat yields exactly one
// result beat on o_out_data. Both channels use valid and stall.
// The block works on one beat at a time: o_in_stall is high from the
// accepting edge until the result has been loaded into the output register.
// Every operation first streams all table slots from the record memory
// through a six-stage prediction pipeline to find the key; a next-hop query
// whose key is found then streams all slots a second time to rank the
// neighbors. Each pass reads the memory once per slot. A result held by a
// stalled receiver stays in the output register and keeps the next result
// from being loaded.
// Reset clears all valid bits, the entry count and the control state, and
// sets the range register to 250. The range register is written through the
// APB-style port at addresses 0 to 3; the user must write it only while the
// block is idle, which the block itself does not enforce.
module greedy_geo_next_hop_table import ggnh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_range;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= RANGE_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_range <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_range};

    ggnh_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    ggnh_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in_data  (i_in_data),
        .i_range    (r_range),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the greedy geographic next-hop table.
module tb;
    import ggnh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 900000;
    localparam int DRAIN_CYCLES = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    greedy_geo_next_hop_table i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Table shadow used to predict each result.
    logic [15:0]      range_shadow;
    logic             shadow_valid [DEPTH];
    logic [31:0]      shadow_key   [DEPTH];
    logic [2:0][15:0] shadow_pos   [DEPTH];
    logic [2:0][15:0] shadow_vel   [DEPTH];
    logic [15:0]      shadow_stamp [DEPTH];
    int               shadow_count;

    t_out_item expected_results[$];
    int        error_count;
    int        cycle_count;
    int        sender_idle_pct;
    int        receiver_stall_pct;
    int        hold_cycles;
    logic [31:0] key_pool [20];
    logic [15:0] clock_now;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [2:0][15:0] predicted_pos(int s, logic [15:0] now);
        logic [15:0]      dt;
        logic [2:0][15:0] p;
        dt = now - shadow_stamp[s];
        for (int a = 0; a < 3; a++) begin
            p[a] = shadow_pos[s][a] + dt * shadow_vel[s][a];
        end
        return p;
    endfunction

    function automatic logic [63:0] squared_dist(logic [2:0][15:0] u, logic [2:0][15:0] v);
        logic [63:0] sum;
        logic [63:0] d;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            d = (u[k] > v[k]) ? 64'(u[k] - v[k]) : 64'(v[k] - u[k]);
            sum += d * d;
        end
        return sum;
    endfunction

    function automatic t_out_item table_op(t_in_item it);
        t_out_item        r;
        int               s;
        int               free_slot;
        logic [2:0][15:0] me;
        logic [2:0][15:0] dst;
        logic [2:0][15:0] p;
        logic [63:0]      r2;
        logic [63:0]      d;
        logic [63:0]      best_d;
        logic [31:0]      best_a;
        logic             any;
        r = '0;
        s = -1;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (shadow_valid[i] && shadow_key[i] == it.node_addr) s = i;
        end
        case (it.func)
            FN_ADD: begin
                free_slot = -1;
                for (int i = DEPTH - 1; i >= 0; i--) begin
                    if (!shadow_valid[i]) free_slot = i;
                end
                if (s < 0 && free_slot >= 0) begin
                    shadow_key[free_slot] = it.node_addr;
                    shadow_pos[free_slot] = {it.pos_z, it.pos_y, it.pos_x};
                    shadow_vel[free_slot] = {it.vel_z, it.vel_y, it.vel_x};
                    shadow_stamp[free_slot] = it.stamp_or_now;
                    shadow_valid[free_slot] = 1'b1;
                    shadow_count++;
                    r.success = 1'b1;
                end
            end
            FN_UPDATE: begin
                if (s >= 0) begin
                    shadow_pos[s] = {it.pos_z, it.pos_y, it.pos_x};
                    shadow_vel[s] = {it.vel_z, it.vel_y, it.vel_x};
                    shadow_stamp[s] = it.stamp_or_now;
                    r.success = 1'b1;
                end
            end
            FN_DELETE: begin
                if (s >= 0) begin
                    shadow_valid[s] = 1'b0;
                    shadow_count--;
                    r.success = 1'b1;
                end
            end
            FN_LOOKUP: begin
                if (s >= 0) begin
                    r.success = 1'b1;
                    {r.res_z, r.res_y, r.res_x} = shadow_pos[s];
                    {r.res_vz, r.res_vy, r.res_vx} = shadow_vel[s];
                    r.res_stamp = shadow_stamp[s];
                end
            end
            FN_PREDICT: begin
                if (s >= 0) begin
                    r.success = 1'b1;
                    {r.res_z, r.res_y, r.res_x} = predicted_pos(s, it.stamp_or_now);
                end
            end
            FN_QUERY: begin
                if (s >= 0) begin
                    me = {it.pos_z, it.pos_y, it.pos_x};
                    dst = predicted_pos(s, it.stamp_or_now);
                    r2 = 64'(range_shadow) * 64'(range_shadow);
                    any = 1'b0;
                    best_d = 0;
                    best_a = 0;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (shadow_valid[i]) begin
                            p = predicted_pos(i, it.stamp_or_now);
                            if (squared_dist(p, me) <= r2) begin
                                d = squared_dist(p, dst);
                                if (!any || d < best_d || (d == best_d && shadow_key[i] < best_a)) begin
                                    best_d = d;
                                    best_a = shadow_key[i];
                                    any = 1'b1;
                                end
                            end
                        end
                    end
                    if (any) begin
                        r.recovery_ok = 1'b1;
                        if (squared_dist(dst, me) > best_d) begin
                            r.next_hop = best_a;
                            r.success = (best_a != 0);
                        end
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = 5'(shadow_count);
        return r;
    endfunction

    // Input beats are predicted as they are accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_results.push_back(table_op(i_in_data));
        end
    end

    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %h, got %h", name, e, a);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no expectation waiting");
                error_count++;
            end else begin
                e = expected_results.pop_front();
                check_field("success", e.success, o_out_data.success);
                check_field("next_hop", e.next_hop, o_out_data.next_hop);
                check_field("res_x", e.res_x, o_out_data.res_x);
                check_field("res_y", e.res_y, o_out_data.res_y);
                check_field("res_z", e.res_z, o_out_data.res_z);
                check_field("res_vx", e.res_vx, o_out_data.res_vx);
                check_field("res_vy", e.res_vy, o_out_data.res_vy);
                check_field("res_vz", e.res_vz, o_out_data.res_vz);
                check_field("res_stamp", e.res_stamp, o_out_data.res_stamp);
                check_field("entry_count", e.entry_count, o_out_data.entry_count);
                check_field("recovery_ok", e.recovery_ok, o_out_data.recovery_ok);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            i_in_data = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = it;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_range(logic [15:0] value);
        wait_idle();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = 3'd0;
        pwdata = {16'($urandom_range(65535)), value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        range_shadow = value;
    endtask

    function automatic t_in_item make_op(logic [2:0] f, logic [31:0] addr,
                                         logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                         logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                                         logic [15:0] st);
        t_in_item it;
        it.func = f;
        it.node_addr = addr;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.vel_x = vx;
        it.vel_y = vy;
        it.vel_z = vz;
        it.stamp_or_now = st;
        return it;
    endfunction

    function automatic logic [15:0] near_coord();
        return ($urandom_range(99) < 80) ? 16'(1000 + $urandom_range(400)) : 16'($urandom);
    endfunction

    function automatic logic [15:0] small_vel();
        return ($urandom_range(99) < 80) ? 16'($urandom_range(6) - 3) : 16'($urandom);
    endfunction

    function automatic t_in_item random_op();
        int          w;
        logic [2:0]  f;
        logic [31:0] addr;
        logic [15:0] st;
        w = $urandom_range(99);
        if (w < 22) f = FN_ADD;
        else if (w < 36) f = FN_UPDATE;
        else if (w < 50) f = FN_DELETE;
        else if (w < 62) f = FN_LOOKUP;
        else if (w < 74) f = FN_PREDICT;
        else if (w < 97) f = FN_QUERY;
        else f = 3'($urandom_range(6, 7));
        addr = ($urandom_range(99) < 85) ? key_pool[$urandom_range(19)] : $urandom;
        clock_now += 16'($urandom_range(3));
        st = ($urandom_range(99) < 85) ? clock_now - 16'($urandom_range(5)) : 16'($urandom);
        return make_op(f, addr, near_coord(), near_coord(), near_coord(),
                       small_vel(), small_vel(), small_vel(), st);
    endfunction

    task automatic test_directed();
        send_item(make_op(FN_LOOKUP, 32'h1, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_op(FN_QUERY, 32'h1, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_op(FN_ADD, 32'hA, 1000, 1000, 1000, 0, 0, 0, 0));
        send_item(make_op(FN_ADD, 32'hA, 1, 2, 3, 0, 0, 0, 0));
        send_item(make_op(FN_ADD, 32'h20, 1100, 1000, 1000, 0, 0, 0, 0));
        send_item(make_op(FN_ADD, 32'h10, 1100, 1000, 1000, 0, 0, 0, 0));
        send_item(make_op(FN_ADD, 32'hD, 1500, 1000, 1000, 0, 0, 0, 0));
        send_item(make_op(FN_QUERY, 32'hD, 900, 1000, 1000, 0, 0, 0, 0));
        send_item(make_op(FN_QUERY, 32'hD, 1500, 1000, 1000, 0, 0, 0, 0));
        send_item(make_op(FN_QUERY, 32'hD, 9000, 9000, 9000, 0, 0, 0, 0));
        send_item(make_op(FN_ADD, 32'h0, 1200, 1000, 1000, 0, 0, 0, 0));
        send_item(make_op(FN_QUERY, 32'hD, 1000, 1000, 1000, 0, 0, 0, 0));
        send_item(make_op(FN_ADD, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF));
        send_item(make_op(FN_LOOKUP, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_op(FN_PREDICT, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 16'h0005));
        send_item(make_op(FN_UPDATE, 32'hFFFFFFFF, 0, 0, 0, 16'h8000, 16'h7FFF, 1, 0));
        send_item(make_op(FN_PREDICT, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 16'hFFFF));
        send_item(make_op(FN_UPDATE, 32'h1234, 5, 5, 5, 0, 0, 0, 0));
        send_item(make_op(FN_DELETE, 32'h1234, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_op(FN_PREDICT, 32'h1234, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_op(3'd6, 32'hA, 1, 1, 1, 1, 1, 1, 1));
        send_item(make_op(3'd7, 32'hA, 16'hFFFF, 0, 0, 0, 0, 0, 0));
        send_item(make_op(FN_DELETE, 32'hA, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_op(FN_LOOKUP, 32'hA, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_full_table();
        for (int i = 0; i < DEPTH + 2; i++) begin
            send_item(make_op(FN_ADD, 32'h100 + i, near_coord(), near_coord(), near_coord(),
                              small_vel(), small_vel(), small_vel(), 16'(i)));
        end
        send_item(make_op(FN_QUERY, 32'h105, 1200, 1200, 1200, 0, 0, 0, 16'd20));
        for (int i = 0; i < DEPTH + 2; i++) begin
            send_item(make_op(FN_DELETE, 32'h100 + i, 0, 0, 0, 0, 0, 0, 0));
        end
    endtask

    task automatic test_random(int n, int idle_pct, int stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) send_item(random_op());
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        @(negedge i_clk);
        hold_cycles = 400;
        for (int i = 0; i < 20; i++) send_item(random_op());
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        clock_now = 16'($urandom);
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        range_shadow = RANGE_RESET;
        shadow_count = 0;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i] = '0;
            shadow_pos[i] = '0;
            shadow_vel[i] = '0;
            shadow_stamp[i] = '0;
        end
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFFFFFF;
        for (int i = 2; i < 20; i++) key_pool[i] = $urandom;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_full_table();
        test_random(150, 0, 0);
        write_range(16'd0);
        test_random(80, 62, 0);
        write_range(16'd65535);
        test_random(150, 0, 62);
        write_range(16'd300);
        test_random(300, 26, 26);
        write_range(16'($urandom_range(100, 600)));
        test_backpressure();
        test_random(400, $urandom_range(0, 62), $urandom_range(0, 62));
        wait_idle();

        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- greedy_geo_next_hop_table.f -----
hdl/ggnh_pkg.sv
hdl/ggnh_ram.sv
hdl/ggnh_ctrl.sv
hdl/ggnh_dpath.sv
hdl/greedy_geo_next_hop_table.sv
verif/tb.sv
